// ===== hdl/psswl_pkg.sv =====
// package for the per-source sliding window limiter
// holds verdict codes, mode codes, register indexes, fixed sizes and a mask helper; no dependencies
package psswl_pkg;

    // log depth per source and width of a logged time
    localparam int LOG_DEPTH = 16;
    localparam int TIME_BITS = 48;

    localparam logic [1:0] VERDICT_PASS   = 2'd0;
    localparam logic [1:0] VERDICT_BLOCK  = 2'd1;
    localparam logic [1:0] VERDICT_REPORT = 2'd2;
    localparam logic [1:0] VERDICT_FULL   = 2'd3;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_BLOCK  = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] REG_LIMIT  = 3'd0;
    localparam logic [2:0] REG_WINDOW = 3'd1;
    localparam logic [2:0] REG_MODE   = 3'd2;
    localparam logic [2:0] REG_STATUS = 3'd3;
    localparam logic [2:0] REG_PFX_V4 = 3'd4;
    localparam logic [2:0] REG_PFX_V6 = 3'd5;

    localparam logic [9:0] STATUS_RESET = 10'd429;

    // leading ones mask of n bits over a 64 bit word
    function automatic logic [63:0] lead_mask(input logic [7:0] n);
        logic [63:0] m;
        m = '0;
        if (n >= 8'd64) begin
            m = '1;
        end else if (n != 8'd0) begin
            m = ~(64'hffff_ffff_ffff_ffff >> n[5:0]);
        end
        return m;
    endfunction

endpackage

// ===== hdl/psswl_key.sv =====
// builds the masked source key from an address and prefix lengths
// depends on psswl_pkg
module psswl_key
    import psswl_pkg::*;
(
    input  logic [63:0] i_addr_upper,
    input  logic [63:0] i_addr_lower,
    input  logic        i_is_v4,
    input  logic [5:0]  i_pfx_v4,
    input  logic [7:0]  i_pfx_v6,
    output logic [63:0] o_key_upper,
    output logic [63:0] o_key_lower
);

    logic [7:0]  p4;
    logic [7:0]  p6;
    logic [63:0] m4;

    // saturate prefix lengths and mask
    always_comb begin
        p4 = (i_pfx_v4 > 6'd32) ? 8'd32 : {2'b00, i_pfx_v4};
        p6 = (i_pfx_v6 > 8'd128) ? 8'd128 : i_pfx_v6;
        m4 = lead_mask(p4) >> 32;
        if (i_is_v4) begin
            o_key_upper = '0;
            o_key_lower = i_addr_lower & m4;
        end else begin
            o_key_upper = i_addr_upper & lead_mask((p6 >= 8'd64) ? 8'd64 : p6);
            o_key_lower = i_addr_lower & lead_mask((p6 >= 8'd64) ? p6 - 8'd64 : 8'd0);
        end
    end

endmodule

// ===== hdl/per_source_sliding_window_limiter_unit.sv =====
// top level of the per-source sliding window limiter
// depends on psswl_pkg and psswl_key
//
// Each request word runs through a small sequencer. The table search takes each
// source entry in turn: the entry's key and count are read from their memories,
// then the newest logged time is read from the log memory, then the match and free
// tests are made. A match ends the search at that entry; a new source searches all
// entries and then claims the lowest free entry, or gets a full verdict if none is
// free. A matched source then reads each logged time, tests it against now - window
// and compacts it, then ends the scan, and a write-back step loads the result
// register; the sequencer then returns to idle to take the next word. In off mode
// the result is loaded at the accept itself. The result word sits in an output
// register and the next request is accepted while it waits; write-back stalls only
// while an earlier result is still unaccepted, and an off-mode request waits for
// the register to empty.
module per_source_sliding_window_limiter_unit
    import psswl_pkg::*;
#(
    parameter int SOURCE_ENTRIES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // addr_upper[63:0], addr_lower[127:64], now_ms[175:128]
    input  logic [175:0] s_axis_tdata,
    // is_v4[0]
    input  logic         s_axis_tuser,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // verdict[1:0], status_code[11:2], hit_count[16:12], zero pad
    output logic [23:0]  m_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready
);

    localparam int EW = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
    localparam int LW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int AW = EW + LW;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SRCH, ST_SRCHL, ST_SRCHW, ST_SCAN, ST_SCANW, ST_FIN, ST_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [4:0]  r_limit;
    logic [31:0] r_window;
    logic [1:0]  r_mode;
    logic [9:0]  r_status;
    logic [5:0]  r_pfx4;
    logic [7:0]  r_pfx6;

    // source table: valid in flip-flops, keys and counts in memories read through registers
    logic [SOURCE_ENTRIES-1:0] r_valid;
    logic [CW-1:0]             r_count [SOURCE_ENTRIES];
    logic [63:0]               r_ku    [SOURCE_ENTRIES];
    logic [63:0]               r_kl    [SOURCE_ENTRIES];
    logic                      r_kv4   [SOURCE_ENTRIES];
    logic [TIME_BITS-1:0]      r_tlog  [SOURCE_ENTRIES*LOG_DEPTH];
    logic [TIME_BITS-1:0]      r_rd;
    logic [CW-1:0]             r_rd_cnt;
    logic [63:0]               r_rd_ku, r_rd_kl;
    logic                      r_rd_kv4;

    // per-request registers
    logic [63:0]          r_req_ku, r_req_kl;
    logic                 r_req_v4;
    logic [TIME_BITS-1:0] r_now;
    logic [EW:0]          r_e;
    logic [EW-1:0]        r_hit, r_free;
    logic                 r_free_ok;
    logic [CW-1:0]        r_i, r_k, r_c;
    logic [23:0]          r_out;
    logic                 r_out_valid;

    logic [63:0] key_u, key_l;
    logic [TIME_BITS-1:0] now_in;
    logic [TIME_BITS-1:0] win;
    logic                 old_ok;
    logic [TIME_BITS-1:0] cut;
    logic [CW-1:0]        lim;
    logic [EW-1:0]        e_idx;
    logic [AW-1:0]        rd_addr;
    logic                 out_free;
    logic                 out_set;

    psswl_key u_key (
        .i_addr_upper (s_axis_tdata[63:0]),
        .i_addr_lower (s_axis_tdata[127:64]),
        .i_is_v4      (s_axis_tuser),
        .i_pfx_v4     (r_pfx4),
        .i_pfx_v6     (r_pfx6),
        .o_key_upper  (key_u),
        .o_key_lower  (key_l)
    );

    // stale threshold and effective limit
    always_comb begin
        now_in = TIME_BITS'(s_axis_tdata[175:128]);
        win    = TIME_BITS'(r_window);
        old_ok = ({{(64-TIME_BITS){1'b0}}, r_now} >= {32'd0, r_window});
        cut    = r_now - win;
        if (r_limit == 5'd0) begin
            lim = CW'(1);
        end else if (32'(r_limit) > LOG_DEPTH) begin
            lim = CW'(LOG_DEPTH);
        end else begin
            lim = CW'(r_limit);
        end
        e_idx = r_e[EW-1:0];
    end

    // result register load and room for a new result
    always_comb begin
        out_free = !r_out_valid || m_axis_tready;
        out_set  = 1'b0;
        if (r_state == ST_IDLE) begin
            out_set = s_axis_tvalid && s_axis_tready && (r_mode == MODE_OFF);
        end else if (r_state == ST_FIN) begin
            out_set = !r_free_ok && out_free;
        end else if (r_state == ST_OUT) begin
            out_set = out_free;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE) && ((r_mode != MODE_OFF) || !r_out_valid);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // log memory read address: newest time during search, index i during scan
    always_comb begin
        if (r_state == ST_SRCHL) begin
            rd_addr = {e_idx, LW'((r_rd_cnt == '0) ? CW'(0) : r_rd_cnt - CW'(1))};
        end else begin
            rd_addr = {r_hit, r_i[LW-1:0]};
        end
    end

    // memory read ports
    always_ff @(posedge i_clk) begin
        r_rd     <= r_tlog[rd_addr];
        r_rd_cnt <= r_count[e_idx];
        r_rd_ku  <= r_ku[e_idx];
        r_rd_kl  <= r_kl[e_idx];
        r_rd_kv4 <= r_kv4[e_idx];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= 5'd10;
            r_window <= 32'd1000;
            r_mode   <= MODE_OFF;
            r_status <= STATUS_RESET;
            r_pfx4   <= 6'd32;
            r_pfx6   <= 8'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LIMIT:  r_limit  <= i_cfg_data[4:0];
                REG_WINDOW: r_window <= i_cfg_data;
                REG_MODE:   r_mode   <= i_cfg_data[1:0];
                REG_STATUS: r_status <= i_cfg_data[9:0];
                REG_PFX_V4: r_pfx4   <= i_cfg_data[5:0];
                REG_PFX_V6: r_pfx6   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_req_ku  <= key_u;
                        r_req_kl  <= key_l;
                        r_req_v4  <= s_axis_tuser;
                        r_now     <= now_in;
                        r_e       <= '0;
                        r_free_ok <= 1'b0;
                        if (r_mode == MODE_OFF) begin
                            r_out <= '0;
                        end else begin
                            r_state <= ST_SRCH;
                        end
                    end
                end
                ST_SRCH: begin
                    r_state <= ST_SRCHL;
                end
                ST_SRCHL: begin
                    r_state <= ST_SRCHW;
                end
                ST_SRCHW: begin
                    // match test and free test on entry e
                    if (r_valid[e_idx] && r_rd_kv4 == r_req_v4 &&
                        r_rd_ku == r_req_ku && r_rd_kl == r_req_kl) begin
                        r_hit <= e_idx;
                    end else if (!r_free_ok && (!r_valid[e_idx] || r_rd_cnt == '0 ||
                                 (old_ok && r_rd < cut))) begin
                        r_free_ok <= 1'b1;
                        r_free    <= e_idx;
                    end
                    if (r_valid[e_idx] && r_rd_kv4 == r_req_v4 &&
                        r_rd_ku == r_req_ku && r_rd_kl == r_req_kl) begin
                        r_i <= '0; r_k <= '0; r_c <= r_rd_cnt;
                        r_state <= ST_SCAN;
                    end else if (r_e == (EW+1)'(SOURCE_ENTRIES - 1)) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_e     <= r_e + 1'b1;
                        r_state <= ST_SRCH;
                    end
                end
                ST_SCAN: begin
                    if (r_i == r_c) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_SCANW;
                    end
                end
                ST_SCANW: begin
                    // keep a fresh time at position k
                    if (!(old_ok && r_rd < cut)) begin
                        r_tlog[{r_hit, r_k[LW-1:0]}] <= r_rd;
                        r_k <= r_k + 1'b1;
                    end
                    r_i     <= r_i + 1'b1;
                    r_state <= ST_SCAN;
                end
                ST_FIN: begin
                    // no match: claim lowest free entry or report full
                    if (!r_free_ok) begin
                        if (out_free) begin
                            r_out   <= {7'd0, 5'd0, 10'd0, VERDICT_FULL};
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_hit          <= r_free;
                        r_valid[r_free] <= 1'b1;
                        r_kv4[r_free]  <= r_req_v4;
                        r_ku[r_free]   <= r_req_ku;
                        r_kl[r_free]   <= r_req_kl;
                        r_k            <= '0;
                        r_state        <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // write back once the result register has room
                    if (out_free) begin
                        if (r_k < lim) begin
                            r_tlog[{r_hit, r_k[LW-1:0]}] <= r_now;
                            r_count[r_hit] <= r_k + 1'b1;
                            r_out <= {7'd0, 5'(r_k + 1'b1), 10'd0, VERDICT_PASS};
                        end else if (r_mode == MODE_BLOCK) begin
                            r_count[r_hit] <= r_k;
                            r_out <= {7'd0, 5'(r_k), r_status, VERDICT_BLOCK};
                        end else begin
                            r_count[r_hit] <= r_k;
                            r_out <= {7'd0, 5'(r_k), 10'd0, VERDICT_REPORT};
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // result word valid flag
            if (out_set) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== dv/per_source_sliding_window_limiter_unit_tb.sv =====
// testbench for per_source_sliding_window_limiter_unit: directed and random request words
// checked against an in-bench limiter predictor; depends on psswl_pkg and the rtl
`timescale 1ns / 1ps

module per_source_sliding_window_limiter_unit_tb
    import psswl_pkg::*;
();

    localparam int ENTRIES    = 64;
    localparam int DEPTH      = 16;
    localparam int MAX_CYCLES = 2_500_000;
    localparam int DRAIN      = 300;

    typedef struct packed {
        logic [4:0] hit;
        logic [9:0] status;
        logic [1:0] verdict;
    } t_limiter_word;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [175:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [23:0]  m_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;

    per_source_sliding_window_limiter_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready)
    );

    always #4 i_clk = ~i_clk;

    // shadow registers
    logic [4:0]  lim_reg    = 5'd10;
    logic [31:0] window_reg = 32'd1000;
    logic [1:0]  mode_reg   = MODE_OFF;
    logic [9:0]  status_reg = STATUS_RESET;
    logic [5:0]  pfx4_reg   = 6'd32;
    logic [7:0]  pfx6_reg   = 8'd64;

    // shadow source table
    logic        src_valid [ENTRIES];
    logic [63:0] src_up    [ENTRIES];
    logic [63:0] src_lo    [ENTRIES];
    logic        src_v4    [ENTRIES];
    logic [4:0]  src_cnt   [ENTRIES];
    logic [47:0] src_log   [ENTRIES][DEPTH];

    t_limiter_word verdict_q[$];
    logic [47:0]   cur_ms = '0;
    int            snd_idle = 0;
    int            rcv_idle = 0;
    bit            failed = 0;
    bit            hold_start = 0;
    logic          hold_active = 1'b0;
    int            cycles = 0;

    // address pool for random traffic
    logic [63:0] pool_up [80];
    logic [63:0] pool_lo [80];
    logic        pool_v4 [80];

    function automatic logic [63:0] top_ones(input int n);
        if (n <= 0) return 64'd0;
        if (n >= 64) return '1;
        return ~({64{1'b1}} >> n);
    endfunction

    function automatic bit is_old(input logic [47:0] t, input logic [47:0] now);
        logic [63:0] n64;
        logic [63:0] w64;
        n64 = {16'd0, now};
        w64 = {32'd0, window_reg};
        return (n64 >= w64) && ({16'd0, t} < n64 - w64);
    endfunction

    // sliding window decision, updates the shadow table
    function automatic t_limiter_word judge_request(input logic [63:0] up, input logic [63:0] lo,
                                                    input logic v4, input logic [47:0] now);
        t_limiter_word r;
        logic [63:0]   ku;
        logic [63:0]   kl;
        int            p;
        int            lim;
        int            slot;
        int            c;
        int            k;
        r = '0;
        slot = -1;
        if (mode_reg == MODE_OFF) return r;
        if (v4) begin
            p = (pfx4_reg > 32) ? 32 : pfx4_reg;
            ku = '0;
            kl = lo & (top_ones(p) >> 32);
        end else begin
            p = (pfx6_reg > 128) ? 128 : pfx6_reg;
            ku = up & top_ones(p >= 64 ? 64 : p);
            kl = lo & top_ones(p >= 64 ? p - 64 : 0);
        end
        lim = (lim_reg == 0) ? 1 : ((lim_reg > DEPTH) ? DEPTH : lim_reg);
        for (int e = 0; e < ENTRIES && slot < 0; e++)
            if (src_valid[e] && src_v4[e] == v4 && src_up[e] == ku && src_lo[e] == kl) slot = e;
        if (slot < 0) begin
            for (int e = 0; e < ENTRIES && slot < 0; e++)
                if (!src_valid[e] || src_cnt[e] == 0 || is_old(src_log[e][src_cnt[e] - 1], now))
                    slot = e;
            if (slot < 0) begin
                r.verdict = VERDICT_FULL;
                return r;
            end
            src_valid[slot] = 1'b1;
            src_v4[slot] = v4;
            src_up[slot] = ku;
            src_lo[slot] = kl;
            src_cnt[slot] = '0;
        end
        // drop stale times, keeping order
        c = src_cnt[slot];
        k = 0;
        for (int i = 0; i < c; i++)
            if (!is_old(src_log[slot][i], now)) begin
                src_log[slot][k] = src_log[slot][i];
                k++;
            end
        c = k;
        if (c < lim) begin
            src_log[slot][c] = now;
            c++;
            r.verdict = VERDICT_PASS;
        end else if (mode_reg == MODE_BLOCK) begin
            r.verdict = VERDICT_BLOCK;
            r.status = status_reg;
        end else begin
            r.verdict = VERDICT_REPORT;
        end
        src_cnt[slot] = c[4:0];
        r.hit = c[4:0];
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_limiter_word got;
            t_limiter_word want;
            got = m_axis_tdata[16:0];
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                failed = 1;
            end else begin
                want = verdict_q.pop_front();
                if (got.verdict !== want.verdict) begin
                    $display("%0t: verdict expected %0d actual %0d", $time, want.verdict,
                             got.verdict);
                    failed = 1;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                    failed = 1;
                end
                if (got.hit !== want.hit) begin
                    $display("%0t: hit_count expected %0d actual %0d", $time, want.hit,
                             got.hit);
                    failed = 1;
                end
            end
        end
    end

    // receiver ready with random stalls
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_active && ($urandom_range(99) >= rcv_idle);
    end

    // long receiver hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_start) begin
                hold_active <= 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_active <= 1'b0;
                hold_start = 0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("per_source_sliding_window_limiter_unit_tb failed");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_LIMIT:  lim_reg = val[4:0];
            REG_WINDOW: window_reg = val;
            REG_MODE:   mode_reg = val[1:0];
            REG_STATUS: status_reg = val[9:0];
            REG_PFX_V4: pfx4_reg = val[5:0];
            REG_PFX_V6: pfx6_reg = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_request(input logic [63:0] up, input logic [63:0] lo, input logic v4);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata <= {cur_ms, lo, up};
        s_axis_tuser <= v4;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        verdict_q.push_back(judge_request(up, lo, v4, cur_ms));
    endtask

    // drain all words, then let the search finish before touching registers
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_all(input logic [4:0] lim, input logic [31:0] win, input logic [1:0] md,
                           input logic [9:0] st, input logic [5:0] p4, input logic [7:0] p6);
        cfg_write(REG_LIMIT, 32'(lim));
        cfg_write(REG_WINDOW, win);
        cfg_write(REG_MODE, 32'(md));
        cfg_write(REG_STATUS, 32'(st));
        cfg_write(REG_PFX_V4, 32'(p4));
        cfg_write(REG_PFX_V6, 32'(p6));
    endtask

    // engine off after reset: everything passes, nothing logged
    task automatic test_off_mode();
        send_request('1, '1, 1'b0);
        send_request(64'h0, 64'h0, 1'b1);
        send_request(64'h0, 64'h0, 1'b1);
        wait_idle();
    endtask

    // block mode: limit reached, status code, stale times, address extremes
    task automatic test_block_mode();
        set_all(5'd3, 32'd100, MODE_BLOCK, 10'd999, 6'd32, 8'd128);
        cur_ms = 48'd10;
        repeat (4) send_request(64'h1234, 64'h5678, 1'b0);
        cur_ms += 48'd200;
        send_request(64'h1234, 64'h5678, 1'b0);
        send_request('1, '1, 1'b0);
        send_request(64'h0, 64'h0, 1'b1);
        // ipv4 ignores the upper half and the high lower bits
        send_request('1, 64'hffff_ffff_0000_0000, 1'b1);
        wait_idle();
    endtask

    // report mode, unused mode, limit and prefix out of range, zero prefix
    task automatic test_report_mode();
        set_all(5'd0, 32'd500, MODE_REPORT, 10'd100, 6'd40, 8'd255);
        cur_ms += 48'd10;
        repeat (2) send_request(64'haaaa, 64'hbbbb, 1'b0);
        wait_idle();
        set_all(5'd31, 32'd500, MODE_UNUSED, 10'd100, 6'd0, 8'd0);
        cur_ms += 48'd10;
        repeat (18) send_request({$urandom, $urandom}, {$urandom, $urandom},
                                 1'($urandom_range(1)));
        wait_idle();
    endtask

    // every entry live, then full, then reuse once times go stale
    task automatic test_table_full();
        set_all(5'd1, 32'hffff_ffff, MODE_BLOCK, 10'd429, 6'd32, 8'd128);
        cur_ms += 48'd10;
        for (int i = 0; i < ENTRIES + 1; i++) send_request(64'd0, 64'd1000 + 64'(i), 1'b1);
        wait_idle();
        cfg_write(REG_WINDOW, 32'd1);
        cur_ms += 48'd5;
        send_request(64'd0, 64'd7, 1'b1);
        send_request(64'd0, 64'd1001, 1'b1);
        wait_idle();
    endtask

    task automatic random_config();
        logic [31:0] win;
        logic [4:0]  lim;
        logic [1:0]  md;
        case ($urandom_range(3))
            0: win = 32'd1;
            1: win = 32'hffff_ffff;
            default: win = $urandom_range(2000, 1);
        endcase
        case ($urandom_range(4))
            0: lim = 5'd0;
            1: lim = 5'd16;
            2: lim = 5'd31;
            default: lim = 5'($urandom_range(16, 1));
        endcase
        md = ($urandom_range(9) == 0) ? MODE_OFF : 2'($urandom_range(3, 1));
        set_all(lim, win, md, 10'($urandom_range(999, 100)), 6'($urandom_range(40)),
                ($urandom_range(7) == 0) ? 8'd255 : 8'($urandom_range(140)));
    endtask

    task automatic test_random(input int n_items, input int s_idle, input int r_idle,
                               input bit pressure);
        int pool_n;
        int j;
        logic [63:0] up;
        logic [63:0] lo;
        snd_idle = s_idle;
        rcv_idle = r_idle;
        for (int done = 0; done < n_items; done += 160) begin
            random_config();
            pool_n = $urandom_range(80, 4);
            if (pressure && done == 0) hold_start = 1;
            for (int i = 0; i < 160 && done + i < n_items; i++) begin
                if ($urandom_range(9) == 0) cur_ms += 48'($urandom_range(5000));
                else cur_ms += 48'($urandom_range(40));
                j = $urandom_range(pool_n - 1);
                up = pool_up[j];
                lo = pool_lo[j];
                // disturb bits that the prefix may drop, or a fresh address
                if ($urandom_range(3) == 0) lo ^= {$urandom, $urandom} & 64'h0000_0000_00ff_ffff;
                if ($urandom_range(9) == 0) begin
                    up = {$urandom, $urandom};
                    lo = {$urandom, $urandom};
                end
                send_request(up, lo, pool_v4[j]);
            end
            wait_idle();
        end
    endtask

    // times near the top of the 48 bit range
    task automatic test_time_top();
        set_all(5'd2, 32'd50, MODE_BLOCK, 10'd999, 6'd24, 8'd48);
        cur_ms = 48'hffff_ffff_ff00;
        repeat (4) send_request(64'h77, 64'h88, 1'b0);
        cur_ms = '1;
        repeat (2) send_request(64'h77, 64'h88, 1'b0);
        wait_idle();
    endtask

    initial begin
        for (int e = 0; e < ENTRIES; e++) begin
            src_valid[e] = 1'b0;
            src_cnt[e] = '0;
        end
        for (int i = 0; i < 80; i++) begin
            pool_up[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
            pool_v4[i] = 1'($urandom_range(1));
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_off_mode();
        test_block_mode();
        test_report_mode();
        test_table_full();
        test_random(600, 12, 52, 1'b0);
        test_random(600, 52, 12, 1'b0);
        test_random(600, 0, 0, 1'b1);
        test_time_top();
        if (!failed) begin
            $display("per_source_sliding_window_limiter_unit_tb passed");
        end else begin
            $display("per_source_sliding_window_limiter_unit_tb failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/psswl_pkg.sv
hdl/psswl_key.sv
hdl/per_source_sliding_window_limiter_unit.sv
dv/per_source_sliding_window_limiter_unit_tb.sv
